FILE: design/erlc_pkg.sv
// erlc_pkg: types and constants for the expert residency LRU cache.
// Used by erlc_cell and expert_residency_lru_cache. No dependencies.
package erlc_pkg;

  localparam int          MAX_ENTRIES_DEF = 64;
  localparam int          CAP_W           = 7;
  localparam logic [6:0]  CAP_RESET       = 7'd64;
  localparam logic [31:0] CNT_SAT         = 32'hFFFF_FFFF;

  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  typedef logic [15:0] key_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] layer;
    logic [7:0] expert;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [6:0]  occupancy;
  } out_t;

  // broadcast from control to every cell
  typedef struct packed {
    logic shift;
    key_t key;
  } ctrl_t;

endpackage

FILE: design/expert_residency_lru_cache.sv
// expert_residency_lru_cache: fully associative LRU residency table, top level.
// Holds the cell chain, capacity register, counters and sequencing.
// Depends on erlc_pkg and erlc_cell.
//
//  channel | ports                       | transfer
//  --------+-----------------------------+-------------------------------
//  input   | start, busy, in_req         | start && !busy
//  result  | out_valid, out_res          | out_valid, one cycle, no stall
//  config  | cfg_we, cfg_wdata           | cfg_we
//
// A transaction needs a compare cycle, where all cells check the key in parallel,
// then a shift cycle, where on a load the chain moves one place toward the old end
// up to the hit or insert point. busy covers both; the result strobes in the cycle
// after the shift and the next transaction can be accepted at the edge ending it.
// Reset (synchronous) empties the chain and clears counters; capacity returns to 64.
// The receiver cannot stall the result.
module expert_residency_lru_cache #(
  parameter int MAX_ENTRIES = erlc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  erlc_pkg::in_t         in_req,
  output logic                  out_valid,
  output erlc_pkg::out_t        out_res,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_wdata
);

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CAPW = (CW > erlc_pkg::CAP_W) ? CW : erlc_pkg::CAP_W;

  logic [6:0]          cap_r;
  erlc_pkg::in_t       req_r;
  logic                ph1_r, ph2_r;
  logic                hit_r;
  logic [IW-1:0]       hidx_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [31:0]         hits_r, hits_nxt;
  logic [31:0]         miss_r, miss_nxt;
  logic                out_valid_r;
  erlc_pkg::out_t      out_r;

  erlc_pkg::ctrl_t     ctrl;
  logic [CW-1:0]       limit;
  logic [CAPW-1:0]     cap_eff;
  logic                full;
  logic                is_load;
  logic [IW-1:0]       midx;

  erlc_pkg::key_t      ckey [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0] cvalid;
  logic [MAX_ENTRIES-1:0] match;

  assign busy      = ph1_r | ph2_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign is_load   = (req_r.operation == erlc_pkg::OP_LOAD);

  always_comb begin
    if (cap_r == 7'd0) begin
      cap_eff = CAPW'(1);
    end else if (CAPW'(cap_r) > CAPW'(MAX_ENTRIES)) begin
      cap_eff = CAPW'(MAX_ENTRIES);
    end else begin
      cap_eff = CAPW'(cap_r);
    end
  end

  assign full = CAPW'(count_r) >= cap_eff;

  always_comb begin
    if (hit_r) begin
      limit = CW'(hidx_r);
    end else if (full) begin
      limit = count_r - CW'(1);
    end else begin
      limit = count_r;
    end
  end

  assign ctrl.shift = ph2_r && is_load;
  assign ctrl.key   = {req_r.layer, req_r.expert};

  assign ckey[0]   = ctrl.key;
  assign cvalid[0] = 1'b1;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    erlc_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .limit      (limit),
      .prev_key   (ckey[g]),
      .prev_valid (cvalid[g]),
      .key        (ckey[g+1]),
      .valid      (cvalid[g+1]),
      .match      (match[g])
    );
  end

  // match is one-hot or empty: OR the indexes together
  always_comb begin
    midx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        midx = midx | IW'(i);
      end
    end
  end

  always_comb begin
    hits_nxt  = hits_r;
    miss_nxt  = miss_r;
    count_nxt = count_r;
    if (is_load) begin
      if (hit_r) begin
        if (hits_r != erlc_pkg::CNT_SAT) begin
          hits_nxt = hits_r + 32'd1;
        end
      end else begin
        if (miss_r != erlc_pkg::CNT_SAT) begin
          miss_nxt = miss_r + 32'd1;
        end
        if (!full) begin
          count_nxt = count_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= erlc_pkg::CAP_RESET;
      ph1_r       <= 1'b0;
      ph2_r       <= 1'b0;
      count_r     <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      ph1_r       <= start && !busy;
      ph2_r       <= ph1_r;
      out_valid_r <= ph2_r;
      if (ph2_r) begin
        count_r <= count_nxt;
        hits_r  <= hits_nxt;
        miss_r  <= miss_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_req;
    end
    if (ph1_r) begin
      hit_r  <= |match;
      hidx_r <= midx;
    end
    if (ph2_r) begin
      out_r.hit        <= hit_r;
      out_r.hit_count  <= hits_nxt;
      out_r.miss_count <= miss_nxt;
      out_r.occupancy  <= 7'(count_nxt);
    end
  end

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("occupancy above table size");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cvalid[MAX_ENTRIES:1]) == int'(count_r))
    else $error("valid cells disagree with occupancy");

  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    ph1_r |-> $onehot0(match))
    else $error("key resident in more than one cell");
`endif

endmodule

FILE: design/erlc_cell.sv
// erlc_cell: one recency slot of the LRU chain (key, valid, match).
// Position in the chain is its recency rank. Depends on erlc_pkg.
module erlc_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  erlc_pkg::ctrl_t   ctrl,
  input  logic [CW-1:0]     limit,
  input  erlc_pkg::key_t    prev_key,
  input  logic              prev_valid,
  output erlc_pkg::key_t    key,
  output logic              valid,
  output logic              match
);

  erlc_pkg::key_t key_r;
  logic           valid_r;
  logic           take;

  assign take  = ctrl.shift && (CW'(IDX) <= limit);
  assign match = valid_r && (key_r == ctrl.key);
  assign key   = key_r;
  assign valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= prev_key;
    end
  end

endmodule

FILE: bench/expert_residency_lru_cache_tb.sv
// Self-checking testbench for expert_residency_lru_cache: directed table plus random traffic,
// each result checked against its directed table entry or a behavioral LRU residency predictor.
// Depends on erlc_pkg and the expert_residency_lru_cache RTL.
`timescale 1ns / 1ps

module expert_residency_lru_cache_tb;
  import erlc_pkg::*;

  localparam int ENTRIES     = MAX_ENTRIES_DEF;
  localparam int QUIET_FIRST = 700;
  localparam int QUIET_LAST  = 1000;
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 135;
  localparam int N_ROWS      = 24;

  typedef struct {
    bit         wr_cap;
    logic [6:0] cap;
    in_t        req;
    bit         typed;
    out_t       want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        in_req = '0;
  logic       out_valid;
  out_t       out_res;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  // predictor state
  key_t        slot_key [ENTRIES];
  bit          slot_used [ENTRIES];
  int          slot_age [ENTRIES];
  logic [31:0] hits_seen;
  logic [31:0] misses_seen;
  int          resident;
  logic [6:0]  cap_reg;

  out_t pending_results[$];
  int   err_cnt = 0;
  int   sent = 0;

  dir_row_t dir_rows [N_ROWS] = '{
    '{0, 7'd0, {OP_PROBE, 8'h00, 8'h00}, 1, {1'b0, 32'd0, 32'd0, 7'd0}},
    '{0, 7'd0, {OP_LOAD,  8'h00, 8'h00}, 1, {1'b0, 32'd0, 32'd1, 7'd1}},
    '{0, 7'd0, {OP_LOAD,  8'hFF, 8'hFF}, 1, {1'b0, 32'd0, 32'd2, 7'd2}},
    '{0, 7'd0, {OP_PROBE, 8'hFF, 8'hFF}, 1, {1'b1, 32'd0, 32'd2, 7'd2}},
    '{0, 7'd0, {OP_LOAD,  8'h00, 8'h00}, 1, {1'b1, 32'd1, 32'd2, 7'd2}},
    '{0, 7'd0, {OP_PROBE, 8'h00, 8'hFF}, 1, {1'b0, 32'd1, 32'd2, 7'd2}},
    '{0, 7'd0, {OP_LOAD,  8'hFF, 8'h00}, 1, {1'b0, 32'd1, 32'd3, 7'd3}},
    '{1, 7'd2, '0, 0, '0},
    '{0, 7'd0, {OP_LOAD,  8'h01, 8'h01}, 1, {1'b0, 32'd1, 32'd4, 7'd3}},
    '{0, 7'd0, {OP_PROBE, 8'hFF, 8'hFF}, 1, {1'b0, 32'd1, 32'd4, 7'd3}},
    '{0, 7'd0, {OP_LOAD,  8'hFF, 8'h00}, 1, {1'b1, 32'd2, 32'd4, 7'd3}},
    '{1, 7'd0, '0, 0, '0},
    '{0, 7'd0, {OP_LOAD,  8'hAA, 8'h55}, 0, '0},
    '{0, 7'd0, {OP_LOAD,  8'h55, 8'hAA}, 0, '0},
    '{0, 7'd0, {OP_PROBE, 8'h55, 8'hAA}, 0, '0},
    '{1, 7'd127, '0, 0, '0},
    '{0, 7'd0, {OP_LOAD,  8'h12, 8'h34}, 0, '0},
    '{0, 7'd0, {OP_LOAD,  8'h80, 8'h01}, 0, '0},
    '{0, 7'd0, {OP_LOAD,  8'h7F, 8'hFE}, 0, '0},
    '{0, 7'd0, {OP_PROBE, 8'h80, 8'h01}, 0, '0},
    '{1, 7'd1, '0, 0, '0},
    '{0, 7'd0, {OP_LOAD,  8'h00, 8'h00}, 0, '0},
    '{0, 7'd0, {OP_LOAD,  8'h00, 8'h00}, 0, '0},
    '{0, 7'd0, {OP_PROBE, 8'h12, 8'h34}, 0, '0}
  };

  expert_residency_lru_cache i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_capacity(logic [6:0] c);
    if (c < 7'd1) return 1;
    if (int'(c) > ENTRIES) return ENTRIES;
    return int'(c);
  endfunction

  function automatic out_t lru_predict(in_t r);
    key_t key;
    int   slot;
    int   oldest;
    int   cap;
    bit   hit;
    out_t res;
    key  = {r.layer, r.expert};
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && slot_used[i] && slot_key[i] == key) slot = i;
    end
    hit = (slot >= 0);
    cap = eff_capacity(cap_reg);
    if (r.operation == OP_LOAD) begin
      if (hit) begin
        if (hits_seen != CNT_SAT) hits_seen++;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && slot_age[i] < slot_age[slot]) slot_age[i]++;
        end
        slot_age[slot] = 0;
      end else begin
        if (misses_seen != CNT_SAT) misses_seen++;
        if (resident >= cap) begin
          // evicting the oldest leaves the other ranks where they were
          oldest = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
          end
          if (oldest >= 0) begin
            slot_used[oldest] = 1'b0;
            resident--;
            slot = oldest;
          end
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !slot_used[i]) slot = i;
        end
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i]) slot_age[i]++;
          end
          slot_key[slot]  = key;
          slot_used[slot] = 1'b1;
          slot_age[slot]  = 0;
          resident++;
        end
      end
    end
    res.hit        = hit;
    res.hit_count  = hits_seen;
    res.miss_count = misses_seen;
    res.occupancy  = resident[6:0];
    return res;
  endfunction

  task automatic send_req(input in_t r, input bit typed, input out_t want);
    bit   took;
    out_t pred;
    start  <= 1'b1;
    in_req <= r;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    pred = lru_predict(r);
    pending_results.insert(pending_results.size(), typed ? want : pred);
    sent++;
    if ((sent < QUIET_FIRST || sent >= QUIET_LAST) && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [6:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_reg = v;
  endtask

  function automatic logic [6:0] phase_capacity(int p);
    case (p)
      0: return 7'd3;
      1: return 7'd1;
      2: return 7'd0;
      3: return 7'd8;
      4: return 7'($urandom_range(2, 16));
      5: return 7'd32;
      6: return 7'd64;
      7: return 7'd127;
      8: return 7'($urandom_range(0, 127));
      9: return 7'd5;
      10: return 7'($urandom_range(1, 64));
      default: return 7'd64;
    endcase
  endfunction

  always @(negedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: %h", out_res);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_res.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_res.hit);
          err_cnt++;
        end
        if (out_res.hit_count !== want.hit_count) begin
          $error("hit_count: expected %0d, got %0d", want.hit_count, out_res.hit_count);
          err_cnt++;
        end
        if (out_res.miss_count !== want.miss_count) begin
          $error("miss_count: expected %0d, got %0d", want.miss_count, out_res.miss_count);
          err_cnt++;
        end
        if (out_res.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_res.occupancy);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    key_t       pool[$];
    in_t        r;
    logic [6:0] cap;
    int         n_pool;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i]  = '0;
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
    end
    hits_seen   = '0;
    misses_seen = '0;
    resident    = 0;
    cap_reg     = CAP_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].wr_cap) write_capacity(dir_rows[k].cap);
      else send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      cap = phase_capacity(p);
      write_capacity(cap);
      n_pool = eff_capacity(cap) + eff_capacity(cap) / 2 + 2;
      pool.delete();
      for (int i = 0; i < n_pool; i++) pool.insert(pool.size(), key_t'($urandom));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r.operation = ($urandom_range(0, 99) < 75) ? OP_LOAD : OP_PROBE;
        if ($urandom_range(0, 99) < 85) begin
          {r.layer, r.expert} = pool[$urandom_range(0, pool.size() - 1)];
        end else begin
          r.layer  = 8'($urandom_range(0, 255));
          r.expert = 8'($urandom_range(0, 255));
        end
        send_req(r, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
